// File: design/wlef_pkg.sv
// wlef_pkg: shared types, sizes and codes for the window local extrema flag block
// no dependencies; imported by wlef_ctrl, wlef_datapath and the top level
`default_nettype none
package wlef_pkg;

    // sizing
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HALF   = 7;
    localparam int ROW_LIMIT  = 4096;
    localparam int RING_DEPTH = (2 * MAX_HALF + 1) * MAX_WIDTH;
    localparam int AW         = $clog2(RING_DEPTH);
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = CW + 1;
    localparam int RW         = $clog2(ROW_LIMIT) + 1;
    localparam int HW         = $clog2(MAX_HALF + 1);
    localparam int CNT_W      = $clog2((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1) + 1);
    localparam int LUMA_W     = 18;

    // field widths
    localparam int CFG_W_W    = 11;
    localparam int CFG_H_W    = 13;
    localparam int CFG_K_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int COLOR_W    = 8;
    localparam int IN_DATA_W  = 24;
    localparam int PIX_X_W    = 10;
    localparam int PIX_Y_W    = 12;
    localparam int OUT_DATA_W = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_K      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_CHECK,
        ST_CENTER,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic store;
        logic restart;
        logic start;
        logic rd_center;
        logic center;
        logic step;
        logic accum;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic frame_over;
        logic win_ready;
        logic scan_done;
        logic out_busy;
    } t_sts;

    // wrap a ring address that went at most one depth past the end
    function automatic logic [AW-1:0] ring_wrap(input logic [AW:0] v);
        logic [AW:0] d;
        d = (AW+1)'(RING_DEPTH);
        if (v >= d) begin
            ring_wrap = AW'(v - d);
        end else begin
            ring_wrap = v[AW-1:0];
        end
    endfunction

endpackage
`default_nettype wire

// File: design/wlef_ram.sv
// wlef_ram: generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module wlef_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: design/wlef_ctrl.sv
// wlef_ctrl: sequencer for one item: store, readiness check, window scan, result
// depends on wlef_pkg
`default_nettype none
module wlef_ctrl import wlef_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output t_cmd      o_cmd,
    input  wire t_sts i_sts
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_STORE;
                end
            end
            ST_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                o_cmd.rd_center = 1'b1;
                if (i_sts.frame_over) begin
                    o_cmd.restart = 1'b1;
                    n_state       = ST_IDLE;
                end else if (i_sts.win_ready) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_CENTER;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_CENTER: begin
                o_cmd.center = 1'b1;
                o_cmd.step   = 1'b1;
                n_state      = ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.accum = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            ST_EMIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// File: design/wlef_datapath.sv
// wlef_datapath: config registers, positions, luminance ring, window scan and result register
// depends on wlef_pkg and wlef_ram
`default_nettype none
module wlef_datapath import wlef_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cmd                  i_cmd,
    output t_sts                       o_sts,
    input  wire logic [IN_DATA_W-1:0]  i_pix_data,
    input  wire logic                  i_pix_flush,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [OUT_DATA_W-1:0]      o_out_data,
    output logic                       o_out_last
);

    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [CFG_K_W-1:0] r_cfg_k;

    logic [LUMA_W-1:0] r_luma;
    logic              r_flush;

    logic [CW-1:0] r_in_col, r_out_col;
    logic [RW-1:0] r_in_row, r_out_row;
    logic [AW-1:0] r_in_addr, r_out_addr;

    logic [CW-1:0]     r_x, r_x0, r_lx;
    logic [RW-1:0]     r_y, r_ly;
    logic [AW-1:0]     r_row_addr, r_cell_addr;
    logic              r_issued_last;
    logic [LUMA_W-1:0] r_center;
    logic [CNT_W-1:0]  r_darker, r_brighter;

    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic [WW-1:0]     eff_w;
    logic [RW-1:0]     eff_h;
    logic [HW-1:0]     half;
    logic [RW:0]       ly_full;
    logic [RW-1:0]     ly, y0;
    logic [CW:0]       lx_full;
    logic [WW-1:0]     wm1;
    logic [CW-1:0]     lx, x0;
    logic [HW-1:0]     dy, dx;
    logic [AW:0]       off, start_addr;
    logic [LUMA_W-1:0] w_luma, rdata;
    logic [AW-1:0]     raddr;
    logic              ram_we, restart_cfg, is_min, is_max;
    logic [CW:0]       in_col_inc, out_col_inc;

    // effective sizes
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (r_cfg_w > CFG_W_W'(MAX_WIDTH)) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = RW'(1);
        end else if (r_cfg_h > CFG_H_W'(ROW_LIMIT)) begin
            eff_h = RW'(ROW_LIMIT);
        end else begin
            eff_h = RW'(r_cfg_h);
        end
        if ((r_cfg_k >> 1) > CFG_K_W'(MAX_HALF)) begin
            half = HW'(MAX_HALF);
        end else begin
            half = HW'(r_cfg_k >> 1);
        end
    end

    // window bounds around the next result position
    always_comb begin
        ly_full = (RW+1)'(r_out_row) + (RW+1)'(half);
        if (ly_full > (RW+1)'(eff_h - RW'(1))) begin
            ly = eff_h - RW'(1);
        end else begin
            ly = ly_full[RW-1:0];
        end
        wm1     = eff_w - WW'(1);
        lx_full = (CW+1)'(r_out_col) + (CW+1)'(half);
        if (lx_full > wm1) begin
            lx = wm1[CW-1:0];
        end else begin
            lx = lx_full[CW-1:0];
        end
        if (r_out_row >= RW'(half)) begin
            y0 = r_out_row - RW'(half);
        end else begin
            y0 = '0;
        end
        if (r_out_col >= CW'(half)) begin
            x0 = r_out_col - CW'(half);
        end else begin
            x0 = '0;
        end
        dy  = HW'(r_out_row - y0);
        dx  = HW'(r_out_col - x0);
        off = (AW+1)'(dy) * (AW+1)'(eff_w) + (AW+1)'(dx);
        if ((AW+1)'(r_out_addr) >= off) begin
            start_addr = (AW+1)'(r_out_addr) - off;
        end else begin
            start_addr = (AW+1)'(r_out_addr) + (AW+1)'(RING_DEPTH) - off;
        end
    end

    // status to the controller
    always_comb begin
        o_sts.frame_over = r_out_row >= eff_h;
        o_sts.win_ready  = (r_in_row > ly) || ((r_in_row == ly) && (r_in_col > lx));
        o_sts.scan_done  = r_issued_last;
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    // luminance of the incoming pixel
    assign w_luma = LUMA_W'(i_pix_data[COLOR_W-1:0]) * LUMA_W'(299)
                  + LUMA_W'(i_pix_data[2*COLOR_W-1:COLOR_W]) * LUMA_W'(587)
                  + LUMA_W'(i_pix_data[3*COLOR_W-1:2*COLOR_W]) * LUMA_W'(114);

    assign ram_we      = i_cmd.store && !r_flush && (r_in_row < eff_h);
    assign raddr       = i_cmd.rd_center ? r_out_addr : r_cell_addr;
    assign restart_cfg = i_cfg_we && (i_cfg_index == CFG_WIDTH || i_cfg_index == CFG_HEIGHT
                                      || i_cfg_index == CFG_K);
    assign in_col_inc  = (CW+1)'(r_in_col) + (CW+1)'(1);
    assign out_col_inc = (CW+1)'(r_out_col) + (CW+1)'(1);
    assign is_min      = r_darker <= CNT_W'(r_cfg_k);
    assign is_max      = r_brighter <= CNT_W'(r_cfg_k);

    wlef_ram #(
        .WIDTH (LUMA_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_in_addr),
        .i_wdata (r_luma),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_luma  <= w_luma;
            r_flush <= i_pix_flush;
        end
    end

    // window scan: bounds, cell walk and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issued_last <= 1'b0;
        end else if (i_cmd.start) begin
            r_issued_last <= 1'b0;
        end else if (i_cmd.step) begin
            r_issued_last <= (r_x == r_lx) && (r_y == r_ly);
        end
        if (i_cmd.start) begin
            r_x0        <= x0;
            r_lx        <= lx;
            r_ly        <= ly;
            r_x         <= x0;
            r_y         <= y0;
            r_row_addr  <= start_addr[AW-1:0];
            r_cell_addr <= start_addr[AW-1:0];
            r_darker    <= '0;
            r_brighter  <= '0;
        end
        if (i_cmd.step) begin
            if (r_x == r_lx) begin
                r_x         <= r_x0;
                r_y         <= r_y + RW'(1);
                r_row_addr  <= ring_wrap((AW+1)'(r_row_addr) + (AW+1)'(eff_w));
                r_cell_addr <= ring_wrap((AW+1)'(r_row_addr) + (AW+1)'(eff_w));
            end else begin
                r_x         <= r_x + CW'(1);
                r_cell_addr <= ring_wrap((AW+1)'(r_cell_addr) + (AW+1)'(1));
            end
        end
        if (i_cmd.center) begin
            r_center <= rdata;
        end
        if (i_cmd.accum) begin
            if (rdata < r_center) begin
                r_darker <= r_darker + CNT_W'(1);
            end
            if (rdata > r_center) begin
                r_brighter <= r_brighter + CNT_W'(1);
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_data <= {PIX_Y_W'(r_out_row), PIX_X_W'(r_out_col), is_max, is_min};
            r_out_last <= (out_col_inc >= (CW+1)'(eff_w)) && ((r_out_row + RW'(1)) >= eff_h);
        end
    end

    // config, positions and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= CFG_W_W'(640);
            r_cfg_h     <= CFG_H_W'(480);
            r_cfg_k     <= CFG_K_W'(3);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_addr   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            // input position advance
            if (ram_we) begin
                r_in_addr <= ring_wrap((AW+1)'(r_in_addr) + (AW+1)'(1));
                if (in_col_inc >= (CW+1)'(eff_w)) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + RW'(1);
                end else begin
                    r_in_col <= in_col_inc[CW-1:0];
                end
            end
            // result issue and output position advance
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_out_addr  <= ring_wrap((AW+1)'(r_out_addr) + (AW+1)'(1));
                if (out_col_inc >= (CW+1)'(eff_w)) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + RW'(1);
                    if ((r_out_row + RW'(1)) >= eff_h) begin
                        r_in_col   <= '0;
                        r_in_row   <= '0;
                        r_in_addr  <= '0;
                        r_out_col  <= '0;
                        r_out_row  <= '0;
                        r_out_addr <= '0;
                    end
                end else begin
                    r_out_col <= out_col_inc[CW-1:0];
                end
            end
            // frame restart
            if (i_cmd.restart || restart_cfg) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_addr  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_addr <= '0;
            end
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_cfg_w <= i_cfg_data[CFG_W_W-1:0];
                    CFG_HEIGHT: r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                    CFG_K:      r_cfg_k <= i_cfg_data[CFG_K_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule
`default_nettype wire

// File: design/window_local_extrema_flags.sv
// window_local_extrema_flags: top level, luminance local minimum / maximum flags
// depends on wlef_pkg, wlef_ctrl, wlef_datapath (which holds wlef_ram)
//
// channel      direction  beat contents
// s_axis       in         tdata: red, green, blue; tuser: flush
// m_axis       out        tdata: is_minimum, is_maximum, pixel_x, pixel_y; tlast: frame_end
// cfg          in         write enable, register index, write data
//
// an item with no result passes through accept, store and check
// an item with a result also passes through center, scan and emit:
// the window is read from the single luminance ring port one cell per cycle
// a result waits in the output register; a new item is accepted meanwhile,
// and the next result holds in the emit state until that register drains
// synchronous active-low reset; the ring holds no reset value and needs no clearing pass
`default_nettype none
module window_local_extrema_flags import wlef_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    input  wire logic                  i_s_axis_tuser,  // flush
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,  // is_minimum[0], is_maximum[1],
                                                        // pixel_x[11:2], pixel_y[23:12]
    output logic                       o_m_axis_tlast,  // frame_end
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    wlef_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    wlef_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_pix_data  (i_s_axis_tdata),
        .i_pix_flush (i_s_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata),
        .o_out_last  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
